// ===== rtl/srf_pkg.sv =====
// Shared types and constants for the sliding rank filter with stop detection.
// No dependencies.
package srf_pkg;

  localparam int DATA_W    = 8;
  localparam int BIT_IDX_W = $clog2(DATA_W);
  localparam int RANK_W    = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic [DATA_W-1:0]    sample_t;
  typedef logic [BIT_IDX_W-1:0] bit_idx_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_UPPER = 2'd0;
  localparam cfg_idx_t CFG_LOWER = 2'd1;
  localparam cfg_idx_t CFG_RANK  = 2'd2;

  localparam sample_t UPPER_RST = 8'd20;
  localparam sample_t LOWER_RST = 8'd6;
  localparam rank_t   RANK_RST  = 4'd6;

  // Rank unit status toward the sequencer
  typedef struct packed {
    logic    busy;
    logic    done;
    sample_t value;
  } rank_status_t;

endpackage

// ===== rtl/srf_window.sv =====
// Sample window: shift line of the last WINDOW_LEN samples, oldest at index 0.
// Depends on srf_pkg.
module srf_window #(
  parameter int WINDOW_LEN = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  srf_pkg::sample_t  sample,
  output srf_pkg::sample_t  win [WINDOW_LEN]
);

  srf_pkg::sample_t win_r [WINDOW_LEN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WINDOW_LEN-1] <= sample;
    end
  end

  assign win = win_r;

endmodule

// ===== rtl/srf_rank_unit.sv =====
// Iterative rank selector: MSB-first radix select, one bit per cycle.
// Each step counts live candidates with a zero in the current bit.
// Depends on srf_pkg.
module srf_rank_unit #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  srf_pkg::rank_t        rank,
  input  srf_pkg::sample_t      win [WINDOW_LEN],
  output srf_pkg::rank_status_t status
);

  localparam int KW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CW = $clog2(WINDOW_LEN + 1);

  logic [WINDOW_LEN-1:0] alive_r, alive_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  srf_pkg::bit_idx_t     bit_r;
  srf_pkg::sample_t      value_r;
  logic                  busy_r, done_r;

  logic [WINDOW_LEN-1:0] zero_mask, one_mask;
  logic [CW-1:0]         zero_cnt;
  logic                  take_one;
  logic [KW-1:0]         k_start;

  // Saturate rank to the largest sample
  assign k_start = (int'(rank) >= WINDOW_LEN) ? KW'(WINDOW_LEN - 1) : KW'(rank);

  always_comb begin
    zero_cnt = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      zero_mask[i] = alive_r[i] & ~win[i][bit_r];
      one_mask[i]  = alive_r[i] &  win[i][bit_r];
      zero_cnt     = zero_cnt + CW'(zero_mask[i]);
    end
    take_one  = ({{(CW-KW+1){1'b0}}, k_r} >= {1'b0, zero_cnt});
    alive_nxt = take_one ? one_mask : zero_mask;
    k_nxt     = take_one ? KW'(k_r - KW'(zero_cnt)) : k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      alive_r <= '1;
      k_r     <= k_start;
      bit_r   <= srf_pkg::bit_idx_t'(srf_pkg::DATA_W - 1);
    end else if (busy_r) begin
      alive_r        <= alive_nxt;
      k_r            <= k_nxt;
      value_r[bit_r] <= take_one;
      bit_r          <= bit_r - 1'b1;
    end
  end

  assign status.busy  = busy_r;
  assign status.done  = done_r;
  assign status.value = value_r;

endmodule

// ===== rtl/sliding_rank_filter_stop_detect_unit.sv =====
// Sliding rank filter with stop detection: top level with sequencer and output register.
// Depends on srf_pkg, srf_window, srf_rank_unit.
// From input accept to out_valid: radix steps, finish (done to ST_DONE), then the output load;
// the window shifts on the accept edge itself.
// Input is taken only in IDLE; the rank unit resolves one sample bit per cycle.
// Reset (rst_n low, synchronous): window zero, stop flag 0, thresholds 20/6, rank 6.
module sliding_rank_filter_stop_detect_unit #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  srf_pkg::cfg_idx_t   cfg_index,
  input  logic [7:0]          cfg_wdata,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  srf_pkg::sample_t    in_sample,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_stop,
  output srf_pkg::sample_t    out_ranked_distance
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  srf_pkg::sample_t upper_r, lower_r;
  srf_pkg::rank_t   rank_r;

  // Output register; stop_r is also the sticky flag
  logic             out_valid_r;
  logic             stop_r, stop_nxt;
  srf_pkg::sample_t dist_r;

  logic                  in_acc, out_acc, load_out;
  srf_pkg::sample_t      win [WINDOW_LEN];
  srf_pkg::rank_status_t rank_st;
  srf_pkg::sample_t      v;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  // The output register frees up when empty or being drained this cycle
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= srf_pkg::UPPER_RST;
      lower_r <= srf_pkg::LOWER_RST;
      rank_r  <= srf_pkg::RANK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srf_pkg::CFG_UPPER: upper_r <= cfg_wdata;
        srf_pkg::CFG_LOWER: lower_r <= cfg_wdata;
        srf_pkg::CFG_RANK:  rank_r  <= cfg_wdata[srf_pkg::RANK_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  srf_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_acc),
    .sample   (in_sample),
    .win      (win)
  );

  // Rank unit starts on the accept edge and sees the shifted window next cycle
  srf_rank_unit #(.WINDOW_LEN(WINDOW_LEN)) u_rank (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .rank   (rank_r),
    .win    (win),
    .status (rank_st)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc)       state_nxt = ST_RUN;
      ST_RUN:  if (rank_st.done) state_nxt = ST_DONE;
      ST_DONE: if (load_out)     state_nxt = ST_IDLE;
      default:                   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Stop flag: above upper sets, below upper clears, below lower sets (last wins)
  assign v = rank_st.value;
  always_comb begin
    stop_nxt = stop_r;
    if (v > upper_r) begin
      stop_nxt = 1'b1;
    end
    if (v < upper_r) begin
      stop_nxt = 1'b0;
    end
    if (v < lower_r) begin
      stop_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      stop_r      <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
        stop_r      <= stop_nxt;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      dist_r <= v;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_stop            = stop_r;
  assign out_ranked_distance = dist_r;

  // Checks
  a_acc_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RUN) && rank_st.busy)
    else $error("accepted item did not start the rank unit");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rank_st.done |-> (state_r == ST_RUN))
    else $error("rank unit finished outside RUN");

  a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !rank_st.busy)
    else $error("rank unit busy while idle");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside DONE");

endmodule
